[hw/rtl/assert_macros.svh]
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked check, switched off while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("check failed");
// same, with a message of the caller's choice
`define ASSERT_CLK_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);
`endif

[hw/rtl/smg_pkg.sv]
// ----------------------------------------------------------------------------
// smg_pkg
// Types, constants and tables shared by the sphere mesh point generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package smg_pkg;

    localparam int MAX_SECTORS = 256;
    localparam int MAX_STACKS  = 256;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RADIUS  = 2'd0,
        CFG_SECTORS = 2'd1,
        CFG_STACKS  = 2'd2
    } t_cfg_idx;

    localparam logic [15:0] RADIUS_RST  = 16'd256;
    localparam logic [8:0]  SECTORS_RST = 9'd36;
    localparam logic [8:0]  STACKS_RST  = 9'd18;

    // long division: stages times steps covers a 32 bit quotient
    localparam int DIV_STAGES = 8;
    localparam int DIV_STEPS  = 4;

    // sin / cos series
    localparam int N_TERMS = 7;
    localparam int SC_LAT  = 3 + 3 * N_TERMS + 1;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    localparam logic [7:0] SIN_DIV [N_TERMS] = '{
        8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210
    };
    localparam logic [7:0] COS_DIV [N_TERMS] = '{
        8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182
    };
    localparam logic [31:0] SIN_RECIP [N_TERMS] = '{
        32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156),
        32'((64'd1 << 32) / 64'd210)
    };
    localparam logic [31:0] COS_RECIP [N_TERMS] = '{
        32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132),
        32'((64'd1 << 32) / 64'd182)
    };

    typedef logic signed [31:0] t_q30;

    typedef struct packed {
        logic [16:0] first_index;
        logic [16:0] tex_s;
        logic [16:0] tex_t;
        logic        point_valid;
        logic        tri_a_valid;
        logic        tri_b_valid;
    } t_side;

    typedef struct packed {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [16:0]        tex_s;
        logic [16:0]        tex_t;
        logic [16:0]        first_index;
        logic               tri_a_valid;
        logic               tri_b_valid;
        logic               point_valid;
    } t_result;

endpackage

[hw/rtl/sphere_mesh_point_generator.sv]
// ----------------------------------------------------------------------------
// sphere_mesh_point_generator
// UV sphere grid point to position, normal, texture coordinates and the
// triangles that start at the point.
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  s_axis    in         tvalid tready tdata  (stack, sector)
//  m_axis    out        tvalid tready tdata tuser (geometry, flags)
//  cfg       in         we addr wdata        (radius, sectors, stacks)
//
//  one word accepted per cycle while the output is not stalled, through 38
//  register stages: one input stage, eight division stages, 25 sin/cos
//  stages, four projection stages. the series of seven terms at three stages
//  each makes up most of those stages.
//  reset is synchronous; it empties the pipeline and loads the default
//  radius 1.0, 36 sectors and 18 stacks.
//  the whole pipeline holds while a result waits and m_axis_tready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sphere_mesh_point_generator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [23:0]  i_s_axis_tdata,   // stack_index, sector_index
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t, first_index
    output logic [151:0] o_m_axis_tdata,
    output logic [2:0]   o_m_axis_tuser,   // tri_a_valid, tri_b_valid, point_valid
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata
);
    import smg_pkg::*;

    logic [15:0] r_radius;
    logic [8:0]  r_sector_cnt;
    logic [8:0]  r_stack_cnt;
    logic [8:0]  w_sectors;
    logic [8:0]  w_stacks;
    logic        w_en;

    logic        ph_vld;
    logic [31:0] ph_theta;
    logic [31:0] ph_phi;
    t_side       ph_side;

    logic        sc_theta_vld;
    logic        sc_phi_vld;
    t_q30        st, ct, sp, cp;

    t_side       r_side_dly [SC_LAT];

    logic        pr_vld;
    t_result     pr_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= RADIUS_RST;
            r_sector_cnt <= SECTORS_RST;
            r_stack_cnt  <= STACKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_RADIUS:  r_radius     <= i_cfg_wdata;
                CFG_SECTORS: r_sector_cnt <= i_cfg_wdata[8:0];
                CFG_STACKS:  r_stack_cnt  <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, clip at the maximum
    assign w_sectors = (r_sector_cnt == 9'd0) ? 9'd1 :
                       (r_sector_cnt > 9'(MAX_SECTORS)) ? 9'(MAX_SECTORS) : r_sector_cnt;
    assign w_stacks  = (r_stack_cnt == 9'd0) ? 9'd1 :
                       (r_stack_cnt > 9'(MAX_STACKS)) ? 9'(MAX_STACKS) : r_stack_cnt;

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    smg_phase u_phase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_vld      (i_s_axis_tvalid),
        .i_stack    (i_s_axis_tdata[8:0]),
        .i_sector   (i_s_axis_tdata[17:9]),
        .i_sectors  (w_sectors),
        .i_stacks   (w_stacks),
        .o_vld      (ph_vld),
        .o_ph_theta (ph_theta),
        .o_ph_phi   (ph_phi),
        .o_side     (ph_side)
    );

    smg_sincos u_sc_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (ph_vld),
        .i_phase (ph_theta),
        .o_vld   (sc_theta_vld),
        .o_sin   (st),
        .o_cos   (ct)
    );

    smg_sincos u_sc_phi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (ph_vld),
        .i_phase (ph_phi),
        .o_vld   (sc_phi_vld),
        .o_sin   (sp),
        .o_cos   (cp)
    );

    // texture, index and flags wait alongside the sin/cos pipelines
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side_dly[0] <= ph_side;
            for (int k = 1; k < SC_LAT; k++) begin
                r_side_dly[k] <= r_side_dly[k-1];
            end
        end
    end

    smg_project u_project (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (sc_theta_vld & sc_phi_vld),
        .i_sp     (sp),
        .i_cp     (cp),
        .i_st     (st),
        .i_ct     (ct),
        .i_side   (r_side_dly[SC_LAT-1]),
        .i_radius (r_radius),
        .o_vld    (pr_vld),
        .o_res    (pr_res)
    );

    assign o_m_axis_tvalid = pr_vld;
    assign o_m_axis_tdata  = {2'b00, pr_res.first_index, pr_res.tex_t, pr_res.tex_s,
                              pr_res.norm_z, pr_res.norm_y, pr_res.norm_x,
                              pr_res.pos_z, pr_res.pos_y, pr_res.pos_x};
    assign o_m_axis_tuser  = {pr_res.point_valid, pr_res.tri_b_valid, pr_res.tri_a_valid};

endmodule

[hw/rtl/smg_phase.sv]
// ----------------------------------------------------------------------------
// smg_phase
// Grid point to angle phases, texture coordinates and triangle flags, by
// four pipelined long divisions by the sector and stack counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smg_phase (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [8:0]     i_stack,
    input  logic [8:0]     i_sector,
    input  logic [8:0]     i_sectors,
    input  logic [8:0]     i_stacks,
    output logic           o_vld,
    output logic [31:0]    o_ph_theta,
    output logic [31:0]    o_ph_phi,
    output smg_pkg::t_side o_side
);
    import smg_pkg::*;

    localparam int N_LANES    = 4;
    localparam int LANE_THETA = 0;
    localparam int LANE_PHI   = 1;
    localparam int LANE_TEXS  = 2;
    localparam int LANE_TEXT  = 3;

    typedef struct packed {
        logic [7:0]  rem;
        logic [31:0] w;
        logic [31:0] q;
    } t_lane;

    typedef struct packed {
        logic [16:0] first_index;
        logic        point_valid;
        logic        tri_a_valid;
        logic        tri_b_valid;
        logic        qh_i;
        logic        qh_j;
    } t_pside;

    function automatic t_lane div_step(t_lane v, logic [8:0] d);
        t_lane      o;
        logic [8:0] t;
        o = v;
        for (int n = 0; n < DIV_STEPS; n++) begin
            t   = {o.rem, o.w[31]};
            o.w = {o.w[30:0], 1'b0};
            if (t >= d) begin
                t   = t - d;
                o.q = {o.q[30:0], 1'b1};
            end else begin
                o.q = {o.q[30:0], 1'b0};
            end
            o.rem = t[7:0];
        end
        return o;
    endfunction

    logic       r0_vld;
    logic [8:0] r0_i;
    logic [8:0] r0_j;

    t_lane  n_init [N_LANES];
    t_pside n_pside;
    logic [7:0]  ri;
    logic [7:0]  rj;
    logic [18:0] n_k1;

    t_lane  n_lane [DIV_STAGES][N_LANES];
    t_lane  r_lane [DIV_STAGES][N_LANES];
    t_pside r_pside [DIV_STAGES];
    logic   r_dvld [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_i <= i_stack;
            r0_j <= i_sector;
        end
    end

    // remainder after the integer part, which is 0 or 1 on the grid
    always_comb begin
        ri = (r0_i < i_stacks) ? r0_i[7:0] : 8'd0;
        rj = (r0_j < i_sectors) ? r0_j[7:0] : 8'd0;
        n_k1 = 19'(r0_i) * 19'({1'b0, i_sectors} + 10'd1) + 19'(r0_j);

        n_pside.first_index = n_k1[16:0];
        n_pside.point_valid = (r0_i <= i_stacks) && (r0_j <= i_sectors);
        n_pside.tri_a_valid = (r0_i < i_stacks) && (r0_j < i_sectors) && (r0_i != 9'd0);
        n_pside.tri_b_valid = (r0_i < i_stacks) && (r0_j < i_sectors)
                              && (r0_i != i_stacks - 9'd1);
        n_pside.qh_i = (r0_i == i_stacks);
        n_pside.qh_j = (r0_j == i_sectors);

        n_init[LANE_THETA].rem = rj;
        n_init[LANE_THETA].w   = 32'(i_sectors[8:1]);
        n_init[LANE_THETA].q   = '0;
        // leading step of the phi division is folded into the start value
        n_init[LANE_PHI].rem   = {1'b0, ri[7:1]};
        n_init[LANE_PHI].w     = {ri[0], 31'(i_stacks[8:1])};
        n_init[LANE_PHI].q     = '0;
        // sixteen idle steps shift the remainder in from the top
        n_init[LANE_TEXS].rem  = 8'd0;
        n_init[LANE_TEXS].w    = {16'(rj), 16'(i_sectors[8:1])};
        n_init[LANE_TEXS].q    = '0;
        n_init[LANE_TEXT].rem  = 8'd0;
        n_init[LANE_TEXT].w    = {16'(ri), 16'(i_stacks[8:1])};
        n_init[LANE_TEXT].q    = '0;
    end

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            n_lane[0][l] = div_step(n_init[l], (l % 2 == 1) ? i_stacks : i_sectors);
        end
        for (int s = 1; s < DIV_STAGES; s++) begin
            for (int l = 0; l < N_LANES; l++) begin
                n_lane[s][l] = div_step(r_lane[s-1][l],
                                        (l % 2 == 1) ? i_stacks : i_sectors);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_dvld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_dvld[0] <= r0_vld;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_dvld[s] <= r_dvld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pside[0] <= n_pside;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_pside[s] <= r_pside[s-1];
            end
            for (int s = 0; s < DIV_STAGES; s++) begin
                for (int l = 0; l < N_LANES; l++) begin
                    r_lane[s][l] <= n_lane[s][l];
                end
            end
        end
    end

    assign o_vld      = r_dvld[DIV_STAGES-1];
    assign o_ph_theta = r_lane[DIV_STAGES-1][LANE_THETA].q;
    assign o_ph_phi   = {r_pside[DIV_STAGES-1].qh_i, r_lane[DIV_STAGES-1][LANE_PHI].q[30:0]};

    always_comb begin
        o_side.first_index = r_pside[DIV_STAGES-1].first_index;
        o_side.tex_s       = {r_pside[DIV_STAGES-1].qh_j,
                              r_lane[DIV_STAGES-1][LANE_TEXS].q[15:0]};
        o_side.tex_t       = {r_pside[DIV_STAGES-1].qh_i,
                              r_lane[DIV_STAGES-1][LANE_TEXT].q[15:0]};
        o_side.point_valid = r_pside[DIV_STAGES-1].point_valid;
        o_side.tri_a_valid = r_pside[DIV_STAGES-1].tri_a_valid;
        o_side.tri_b_valid = r_pside[DIV_STAGES-1].tri_b_valid;
    end

endmodule

[hw/rtl/smg_sincos.sv]
// ----------------------------------------------------------------------------
// smg_sincos
// Sine and cosine of a 32 bit phase in Q30: octant fold, Taylor series with
// one term per three stages, clamp and quadrant mapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smg_sincos (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [31:0]   i_phase,
    output logic          o_vld,
    output smg_pkg::t_q30 o_sin,
    output smg_pkg::t_q30 o_cos
);
    import smg_pkg::*;

    localparam t_q30 ONE_Q30 = 32'sd1073741824;

    typedef struct packed {
        logic [1:0]  quad;
        logic        swap;
        logic [29:0] x2;
    } t_ctl;

    function automatic t_q30 clamp_q30(t_q30 v);
        t_q30 o;
        o = v;
        if (v < 0) begin
            o = '0;
        end else if (v > ONE_Q30) begin
            o = ONE_Q30;
        end
        return o;
    endfunction

    // fold and conversion stages
    logic        r1_vld, r2_vld;
    logic [1:0]  r1_quad, r2_quad;
    logic        r1_swap, r2_swap;
    logic [29:0] r1_a;
    logic [29:0] r2_x;
    logic [29:0] n_rem;
    logic        n_swap;
    logic [61:0] n_xprod;
    logic [59:0] n_x2prod;

    // series chain, slot 0 is loaded with the first term
    logic        r_vld [N_TERMS+1];
    logic [30:0] r_ts  [N_TERMS+1];
    logic [30:0] r_tc  [N_TERMS+1];
    t_q30        r_s   [N_TERMS+1];
    t_q30        r_c   [N_TERMS+1];
    t_ctl        r_ctl [N_TERMS+1];

    logic        r_a_vld [N_TERMS];
    logic [29:0] r_a_ps  [N_TERMS];
    logic [29:0] r_a_pc  [N_TERMS];
    t_q30        r_a_s   [N_TERMS];
    t_q30        r_a_c   [N_TERMS];
    t_ctl        r_a_ctl [N_TERMS];

    logic        r_b_vld [N_TERMS];
    logic [29:0] r_b_ps  [N_TERMS];
    logic [29:0] r_b_pc  [N_TERMS];
    logic [29:0] r_b_qs  [N_TERMS];
    logic [29:0] r_b_qc  [N_TERMS];
    t_q30        r_b_s   [N_TERMS];
    t_q30        r_b_c   [N_TERMS];
    t_ctl        r_b_ctl [N_TERMS];

    logic [60:0] n_prod_s [N_TERMS];
    logic [60:0] n_prod_c [N_TERMS];
    logic [61:0] n_rec_s  [N_TERMS];
    logic [61:0] n_rec_c  [N_TERMS];
    logic [29:0] n_rs     [N_TERMS];
    logic [29:0] n_rc     [N_TERMS];
    logic [29:0] n_qs     [N_TERMS];
    logic [29:0] n_qc     [N_TERMS];
    t_q30        n_s      [N_TERMS];
    t_q30        n_c      [N_TERMS];

    logic        r_out_vld;
    t_q30        r_sin, r_cos;
    t_q30        n_s0, n_c0;

    assign n_rem    = i_phase[29:0];
    assign n_swap   = n_rem > 30'h2000_0000;
    assign n_xprod  = 62'(r1_a) * 62'(TWO_PI_Q29);
    assign n_x2prod = 60'(r2_x) * 60'(r2_x);

    always_comb begin
        for (int k = 0; k < N_TERMS; k++) begin
            n_prod_s[k] = 61'(r_ts[k]) * 61'(r_ctl[k].x2);
            n_prod_c[k] = 61'(r_tc[k]) * 61'(r_ctl[k].x2);
            n_rec_s[k]  = 62'(r_a_ps[k]) * 62'(SIN_RECIP[k]);
            n_rec_c[k]  = 62'(r_a_pc[k]) * 62'(COS_RECIP[k]);
            // reciprocal estimate is low by at most one
            n_rs[k] = r_b_ps[k] - 30'(38'(r_b_qs[k]) * 38'(SIN_DIV[k]));
            n_rc[k] = r_b_pc[k] - 30'(38'(r_b_qc[k]) * 38'(COS_DIV[k]));
            n_qs[k] = r_b_qs[k] + 30'(n_rs[k] >= 30'(SIN_DIV[k]));
            n_qc[k] = r_b_qc[k] + 30'(n_rc[k] >= 30'(COS_DIV[k]));
            if (k % 2 == 0) begin
                n_s[k] = r_b_s[k] - $signed({2'b00, n_qs[k]});
                n_c[k] = r_b_c[k] - $signed({2'b00, n_qc[k]});
            end else begin
                n_s[k] = r_b_s[k] + $signed({2'b00, n_qs[k]});
                n_c[k] = r_b_c[k] + $signed({2'b00, n_qc[k]});
            end
        end
    end

    always_comb begin
        t_q30 s_cl;
        t_q30 c_cl;
        s_cl = clamp_q30(r_s[N_TERMS]);
        c_cl = clamp_q30(r_c[N_TERMS]);
        n_s0 = r_ctl[N_TERMS].swap ? c_cl : s_cl;
        n_c0 = r_ctl[N_TERMS].swap ? s_cl : c_cl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= N_TERMS; k++) begin
                r_vld[k] <= 1'b0;
            end
            for (int k = 0; k < N_TERMS; k++) begin
                r_a_vld[k] <= 1'b0;
                r_b_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r1_vld   <= i_vld;
            r2_vld   <= r1_vld;
            r_vld[0] <= r2_vld;
            for (int k = 0; k < N_TERMS; k++) begin
                r_a_vld[k]  <= r_vld[k];
                r_b_vld[k]  <= r_a_vld[k];
                r_vld[k+1]  <= r_b_vld[k];
            end
            r_out_vld <= r_vld[N_TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_quad <= i_phase[31:30];
            r1_swap <= n_swap;
            r1_a    <= n_swap ? 30'(31'h4000_0000 - {1'b0, n_rem}) : n_rem;

            r2_quad <= r1_quad;
            r2_swap <= r1_swap;
            r2_x    <= 30'((n_xprod + (62'd1 << 30)) >> 31);

            r_ts[0]       <= {1'b0, r2_x};
            r_tc[0]       <= 31'h4000_0000;
            r_s[0]        <= $signed({2'b00, r2_x});
            r_c[0]        <= ONE_Q30;
            r_ctl[0].quad <= r2_quad;
            r_ctl[0].swap <= r2_swap;
            r_ctl[0].x2   <= n_x2prod[59:30];

            for (int k = 0; k < N_TERMS; k++) begin
                r_a_ps[k]  <= n_prod_s[k][59:30];
                r_a_pc[k]  <= n_prod_c[k][59:30];
                r_a_s[k]   <= r_s[k];
                r_a_c[k]   <= r_c[k];
                r_a_ctl[k] <= r_ctl[k];

                r_b_ps[k]  <= r_a_ps[k];
                r_b_pc[k]  <= r_a_pc[k];
                r_b_qs[k]  <= n_rec_s[k][61:32];
                r_b_qc[k]  <= n_rec_c[k][61:32];
                r_b_s[k]   <= r_a_s[k];
                r_b_c[k]   <= r_a_c[k];
                r_b_ctl[k] <= r_a_ctl[k];

                r_ts[k+1]  <= {1'b0, n_qs[k]};
                r_tc[k+1]  <= {1'b0, n_qc[k]};
                r_s[k+1]   <= n_s[k];
                r_c[k+1]   <= n_c[k];
                r_ctl[k+1] <= r_b_ctl[k];
            end

            case (r_ctl[N_TERMS].quad)
                2'd0: begin
                    r_sin <= n_s0;
                    r_cos <= n_c0;
                end
                2'd1: begin
                    r_sin <= n_c0;
                    r_cos <= -n_s0;
                end
                2'd2: begin
                    r_sin <= -n_s0;
                    r_cos <= -n_c0;
                end
                default: begin
                    r_sin <= -n_c0;
                    r_cos <= n_s0;
                end
            endcase
        end
    end

    assign o_vld = r_out_vld;
    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

[hw/rtl/smg_project.sv]
// ----------------------------------------------------------------------------
// smg_project
// Direction products, scaling by the radius and final rounding into the
// result word, with the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smg_project (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  smg_pkg::t_q30    i_sp,
    input  smg_pkg::t_q30    i_cp,
    input  smg_pkg::t_q30    i_st,
    input  smg_pkg::t_q30    i_ct,
    input  smg_pkg::t_side   i_side,
    input  logic [15:0]      i_radius,
    output logic             o_vld,
    output smg_pkg::t_result o_res
);
    import smg_pkg::*;

    // round to nearest, halves away from zero
    function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int unsigned n);
        logic [63:0] mag;
        logic [63:0] m;
        mag = v[63] ? 64'(-v) : 64'(v);
        m   = (mag + (64'd1 << (n - 1))) >> n;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    logic               r1_vld, r2_vld, r3_vld, r4_vld;
    logic signed [63:0] r1_px, r1_py;
    t_q30               r1_uz;
    t_side              r1_side, r2_side, r3_side;
    t_q30               r2_ux, r2_uy, r2_uz;
    t_q30               r3_ux, r3_uy, r3_uz;
    logic signed [48:0] r3_px, r3_py, r3_pz;
    t_result            r_res;

    logic signed [63:0] n_ux, n_uy;
    logic signed [63:0] n_pos_x, n_pos_y, n_pos_z;
    logic signed [63:0] n_nrm_x, n_nrm_y, n_nrm_z;
    logic signed [16:0] n_rad;

    assign n_ux  = rnd_shift(r1_px, 30);
    assign n_uy  = rnd_shift(r1_py, 30);
    assign n_rad = $signed({1'b0, i_radius});

    assign n_pos_x = rnd_shift(64'(r3_px), 30);
    assign n_pos_y = rnd_shift(64'(r3_py), 30);
    assign n_pos_z = rnd_shift(64'(r3_pz), 30);
    assign n_nrm_x = rnd_shift(64'(r3_ux), 16);
    assign n_nrm_y = rnd_shift(64'(r3_uy), 16);
    assign n_nrm_z = rnd_shift(64'(r3_uz), 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_px   <= i_sp * i_ct;
            r1_py   <= i_sp * i_st;
            r1_uz   <= i_cp;
            r1_side <= i_side;

            r2_ux   <= n_ux[31:0];
            r2_uy   <= n_uy[31:0];
            r2_uz   <= r1_uz;
            r2_side <= r1_side;

            r3_px   <= n_rad * r2_ux;
            r3_py   <= n_rad * r2_uy;
            r3_pz   <= n_rad * r2_uz;
            r3_ux   <= r2_ux;
            r3_uy   <= r2_uy;
            r3_uz   <= r2_uz;
            r3_side <= r2_side;

            // a point off the grid gives an all-zero word
            if (r3_side.point_valid) begin
                r_res.pos_x       <= n_pos_x[16:0];
                r_res.pos_y       <= n_pos_y[16:0];
                r_res.pos_z       <= n_pos_z[16:0];
                r_res.norm_x      <= n_nrm_x[15:0];
                r_res.norm_y      <= n_nrm_y[15:0];
                r_res.norm_z      <= n_nrm_z[15:0];
                r_res.tex_s       <= r3_side.tex_s;
                r_res.tex_t       <= r3_side.tex_t;
                r_res.first_index <= r3_side.first_index;
                r_res.tri_a_valid <= r3_side.tri_a_valid;
                r_res.tri_b_valid <= r3_side.tri_b_valid;
                r_res.point_valid <= 1'b1;
            end else begin
                r_res <= '0;
            end
        end
    end

    assign o_vld = r4_vld;
    assign o_res = r_res;

endmodule

[hw/rtl/smg_checker.sv]
// ----------------------------------------------------------------------------
// smg_checker
// Port-level checks on the sphere mesh point generator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module smg_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [151:0] o_m_axis_tdata,
    input logic [2:0]   o_m_axis_tuser
);

    // a held result word keeps its payload
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // input side is open whenever the output register is empty
    `ASSERT_CLK(a_ready_free, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready)

    // a point off the grid carries an all-zero word
    `ASSERT_CLK_MSG(a_off_grid_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[2] |-> o_m_axis_tdata == 152'd0 && o_m_axis_tuser == 3'd0, "off-grid word not zero")

    // triangles only start at points on the grid
    `ASSERT_CLK(a_tri_on_grid, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser[0] || o_m_axis_tuser[1]) |-> o_m_axis_tuser[2])

endmodule

bind sphere_mesh_point_generator smg_checker u_smg_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sphere mesh point generator. Grid points are
// streamed in under several register settings; an in-bench fixed point model
// predicts position, normal, texture and triangle flags for every accepted
// word, and each output word is compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import smg_pkg::*;

    localparam logic [1:0] CFG_SPARE   = 2'd3;   // no register behind it
    localparam longint     ONE_Q30     = 64'sd1 << 30;
    localparam int         DRAIN_WAIT  = 60;
    localparam int         CYCLE_LIMIT = 600000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = '0;    // stack_index, sector_index
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;         // pos_x .. first_index, see unpacking below
    logic [2:0]   m_tuser;         // tri_a_valid, tri_b_valid, point_valid
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = CFG_RADIUS;
    logic [15:0]  cfg_wdata = '0;

    sphere_mesh_point_generator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // model copy of the registers
    logic [15:0] mdl_radius  = RADIUS_RST;
    logic [8:0]  mdl_sectors = SECTORS_RST;
    logic [8:0]  mdl_stacks  = STACKS_RST;

    t_result point_queue[$];
    int      fail_count = 0;
    int      words_in = 0;
    int      words_out = 0;
    int      settings_run = 0;
    bit      calm = 1'b0;
    int      cycle_count = 0;

    function automatic longint round_shift(longint v, int n);
        longint h;
        h = 64'sd1 <<< (n - 1);
        if (v >= 0)
            return (v + h) >>> n;
        return -((-v + h) >>> n);
    endfunction

    function automatic longint clamp_count(logic [8:0] c, int cmax);
        if (c == 0)
            return 1;
        return (c > cmax) ? cmax : c;
    endfunction

    function automatic void phase_sin_cos(logic [31:0] phase, output longint sn,
                                          output longint cs);
        logic [1:0]  quad;
        longint      rem, a, x, x2, ts, tc, s, c, s0, c0;
        bit          swap;
        quad = phase[31:30];
        rem  = 64'(phase[29:0]);
        swap = rem > 64'h2000_0000;
        a    = swap ? (64'h4000_0000 - rem) : rem;
        x    = (a * 64'd3373259426 + (64'sd1 << 30)) >>> 31;
        x2   = (x * x) >>> 30;
        ts = x; tc = ONE_Q30; s = x; c = ONE_Q30;
        for (int k = 1; k <= 7; k++) begin
            ts = ((ts * x2) >>> 30) / ((2 * k) * (2 * k + 1));
            tc = ((tc * x2) >>> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                s -= ts; c -= tc;
            end else begin
                s += ts; c += tc;
            end
        end
        if (s < 0) s = 0;
        if (c < 0) c = 0;
        if (s > ONE_Q30) s = ONE_Q30;
        if (c > ONE_Q30) c = ONE_Q30;
        s0 = swap ? c : s;
        c0 = swap ? s : c;
        case (quad)
            2'd0: begin sn = s0;  cs = c0;  end
            2'd1: begin sn = c0;  cs = -s0; end
            2'd2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
    endfunction

    function automatic t_result sphere_point(logic [8:0] row, logic [8:0] col);
        t_result     r;
        longint      ns, nt, i, j, st, ct, sp, cp, ux, uy, uz, rad;
        logic [31:0] ph_theta, ph_phi;
        r   = '0;
        ns  = clamp_count(mdl_sectors, MAX_SECTORS);
        nt  = clamp_count(mdl_stacks, MAX_STACKS);
        i   = 64'(row);
        j   = 64'(col);
        rad = 64'(mdl_radius);
        if (i > nt || j > ns)
            return r;
        ph_theta = 32'(((j <<< 32) + ns / 2) / ns);
        ph_phi   = 32'(((i <<< 31) + nt / 2) / nt);
        phase_sin_cos(ph_theta, st, ct);
        phase_sin_cos(ph_phi, sp, cp);
        ux = round_shift(sp * ct, 30);
        uy = round_shift(sp * st, 30);
        uz = cp;
        r.pos_x       = 17'(round_shift(rad * ux, 30));
        r.pos_y       = 17'(round_shift(rad * uy, 30));
        r.pos_z       = 17'(round_shift(rad * uz, 30));
        r.norm_x      = 16'(round_shift(ux, 16));
        r.norm_y      = 16'(round_shift(uy, 16));
        r.norm_z      = 16'(round_shift(uz, 16));
        r.tex_s       = 17'(((j <<< 16) + ns / 2) / ns);
        r.tex_t       = 17'(((i <<< 16) + nt / 2) / nt);
        r.first_index = 17'(i * (ns + 1) + j);
        r.tri_a_valid = (i < nt && j < ns && i != 0);
        r.tri_b_valid = (i < nt && j < ns && i != nt - 1);
        r.point_valid = 1'b1;
        return r;
    endfunction

    // output side: random stall bursts, none once calm
    int stall_left = 0;
    int run_left   = 0;
    always @(posedge i_clk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (run_left > 0) begin
            m_tready <= 1'b1;
            run_left <= run_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            m_tready <= 1'b1;
            run_left <= $urandom_range(0, 40);
        end
    end

    always @(posedge i_clk) begin
        t_result want, got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.pos_x       = m_tdata[16:0];
            got.pos_y       = m_tdata[33:17];
            got.pos_z       = m_tdata[50:34];
            got.norm_x      = m_tdata[66:51];
            got.norm_y      = m_tdata[82:67];
            got.norm_z      = m_tdata[98:83];
            got.tex_s       = m_tdata[115:99];
            got.tex_t       = m_tdata[132:116];
            got.first_index = m_tdata[149:133];
            got.tri_a_valid = m_tuser[0];
            got.tri_b_valid = m_tuser[1];
            got.point_valid = m_tuser[2];
            words_out++;
            if (point_queue.size() == 0) begin
                $error("unexpected output word");
                fail_count++;
            end else begin
                want = point_queue.pop_front();
                if (got.pos_x !== want.pos_x) begin
                    $error("pos_x expected %0d got %0d", want.pos_x, got.pos_x);
                    fail_count++;
                end
                if (got.pos_y !== want.pos_y) begin
                    $error("pos_y expected %0d got %0d", want.pos_y, got.pos_y);
                    fail_count++;
                end
                if (got.pos_z !== want.pos_z) begin
                    $error("pos_z expected %0d got %0d", want.pos_z, got.pos_z);
                    fail_count++;
                end
                if (got.norm_x !== want.norm_x) begin
                    $error("norm_x expected %0d got %0d", want.norm_x, got.norm_x);
                    fail_count++;
                end
                if (got.norm_y !== want.norm_y) begin
                    $error("norm_y expected %0d got %0d", want.norm_y, got.norm_y);
                    fail_count++;
                end
                if (got.norm_z !== want.norm_z) begin
                    $error("norm_z expected %0d got %0d", want.norm_z, got.norm_z);
                    fail_count++;
                end
                if (got.tex_s !== want.tex_s) begin
                    $error("tex_s expected %0d got %0d", want.tex_s, got.tex_s);
                    fail_count++;
                end
                if (got.tex_t !== want.tex_t) begin
                    $error("tex_t expected %0d got %0d", want.tex_t, got.tex_t);
                    fail_count++;
                end
                if (got.first_index !== want.first_index) begin
                    $error("first_index expected %0d got %0d",
                           want.first_index, got.first_index);
                    fail_count++;
                end
                if (got.tri_a_valid !== want.tri_a_valid) begin
                    $error("tri_a_valid expected %0d got %0d",
                           want.tri_a_valid, got.tri_a_valid);
                    fail_count++;
                end
                if (got.tri_b_valid !== want.tri_b_valid) begin
                    $error("tri_b_valid expected %0d got %0d",
                           want.tri_b_valid, got.tri_b_valid);
                    fail_count++;
                end
                if (got.point_valid !== want.point_valid) begin
                    $error("point_valid expected %0d got %0d",
                           want.point_valid, got.point_valid);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one grid point word; valid stays high into the next call unless a gap
    task automatic send_point(logic [8:0] row, logic [8:0] col);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, col, row};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        point_queue.insert(point_queue.size(), sphere_point(row, col));
        words_in++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (point_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RADIUS:  mdl_radius  = val;
            CFG_SECTORS: mdl_sectors = val[8:0];
            CFG_STACKS:  mdl_stacks  = val[8:0];
            default: ;
        endcase
        settings_run++;
        @(posedge i_clk);
    endtask

    task automatic set_grid(logic [15:0] rad, logic [8:0] sec, logic [8:0] stk);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_SECTORS, {7'd0, sec});
        write_reg(CFG_STACKS, {7'd0, stk});
    endtask

    // poles, seams, corners and points just off the grid
    task automatic test_directed_edges;
        logic [8:0] ns, nt;
        ns = 9'(clamp_count(mdl_sectors, MAX_SECTORS));
        nt = 9'(clamp_count(mdl_stacks, MAX_STACKS));
        send_point(9'd0, 9'd0);
        send_point(nt, ns);
        send_point(nt - 9'd1, ns - 9'd1);
        send_point(9'd1, 9'd1);
        send_point(nt / 9'd2, ns / 9'd2);
        send_point(nt + 9'd1, 9'd0);
        send_point(9'd0, ns + 9'd1);
        send_point(9'h1FF, 9'h1FF);
        drain();
    endtask

    task automatic test_default_grid;
        test_directed_edges();
    endtask

    task automatic test_radius_extremes;
        set_grid(16'd0, 9'd36, 9'd18);
        test_directed_edges();
        set_grid(16'hFFFF, 9'd36, 9'd18);
        test_directed_edges();
    endtask

    // zero counts act as one, oversized counts clamp, spare index ignored
    task automatic test_count_limits;
        set_grid(16'd256, 9'd0, 9'd0);
        test_directed_edges();
        set_grid(16'd300, 9'h1FF, 9'h1FF);
        test_directed_edges();
        set_grid(16'd300, 9'd256, 9'd256);
        send_point(9'd256, 9'd256);
        send_point(9'd128, 9'd64);
        drain();
        write_reg(CFG_SPARE, 16'h00AB);
        send_point(9'd3, 9'd5);
        drain();
    endtask

    task automatic random_batch(int count);
        logic [8:0] row, col;
        longint     ns, nt;
        ns = clamp_count(mdl_sectors, MAX_SECTORS);
        nt = clamp_count(mdl_stacks, MAX_STACKS);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 8) begin
                row = 9'($urandom_range(0, int'(nt)));
                col = 9'($urandom_range(0, int'(ns)));
            end else begin
                row = 9'($urandom);
                col = 9'($urandom);
            end
            send_point(row, col);
        end
        drain();
    endtask

    task automatic test_random_grids;
        logic [8:0] sec, stk;
        for (int p = 0; p < 10; p++) begin
            if (p % 4 == 3) begin
                sec = 9'($urandom);
                stk = 9'($urandom);
            end else begin
                sec = 9'($urandom_range(1, 40));
                stk = 9'($urandom_range(1, 40));
            end
            set_grid(16'($urandom), sec, stk);
            if (p == 9)
                calm = 1'b1;
            random_batch(60);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_grid();
        test_radius_extremes();
        test_count_limits();
        test_random_grids();
        $display("tb: %0d points sent, %0d words checked, %0d register writes",
                 words_in, words_out, settings_run);
        $display("tb: covered poles, seams, off-grid points, count clamping, radius range");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/smg_pkg.sv
hw/rtl/smg_phase.sv
hw/rtl/smg_sincos.sv
hw/rtl/smg_project.sv
hw/rtl/sphere_mesh_point_generator.sv
hw/rtl/smg_checker.sv
verif/testbench.sv
